### src/gtg_pkg.sv
// Shared types, constants and control store for the go-to-goal heading controller.
package gtg_pkg;

  // Field and datapath widths
  localparam int POS_W      = 16;  // Q5.10 positions
  localparam int HEAD_W     = 15;  // Q2.12 heading
  localparam int DIFF_W     = 17;  // goal minus pose
  localparam int ERR_W      = 16;  // heading error
  localparam int PROD_W     = 24;  // error times gain
  localparam int CW         = 28;  // CORDIC x, y and z registers
  localparam int ATAN_LEN   = 24;
  localparam int ITER_W     = 5;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int CORDIC_STEPS_DEF = 14;

  localparam logic signed [CW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [CW-1:0] PI_Q12      = 28'sd12868;
  localparam logic signed [CW-1:0] ROUND_HALF  = 28'sd2048;

  // Register reset values
  localparam logic [11:0] POS_TOL_RST   = 12'd102;
  localparam logic [12:0] ANG_TOL_RST   = 13'd410;
  localparam logic [7:0]  GAIN_RST      = 8'd128;
  localparam logic [11:0] CRUISE_RST    = 12'd205;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE  = 2'd3;

  // Action codes
  localparam logic ACT_SET_GOAL = 1'b0;
  localparam logic ACT_POSE     = 1'b1;

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_CAPTURE,
    OP_DIFF,
    OP_PREROT,
    OP_ITER,
    OP_ROUND,
    OP_ERROR,
    OP_PRODUCT,
    OP_DECIDE,
    OP_EMIT
  } op_t;

  // Step advance conditions; a step holds until its condition is met
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_POSE,
    COND_ITER_DONE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  next;
  } uword_t;

  typedef struct packed {
    op_t               op;
    logic              take;
    logic [ITER_W-1:0] iter;
  } ctl_t;

  typedef struct packed {
    logic [11:0] pos_tol;
    logic [12:0] ang_tol;
    logic [7:0]  gain;
    logic [11:0] cruise;
  } cfg_t;

  typedef struct packed {
    logic [11:0]              linear_speed;
    logic signed [ERR_W-1:0]  angular_rate;
    logic                     goal_reached;
  } result_t;

  // Microprogram
  function automatic uword_t rom_word(input logic [PC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      4'd0:    w = '{op: OP_CAPTURE, cond: COND_POSE,      next: 4'd1};
      4'd1:    w = '{op: OP_DIFF,    cond: COND_ALWAYS,    next: 4'd2};
      4'd2:    w = '{op: OP_PREROT,  cond: COND_ALWAYS,    next: 4'd3};
      4'd3:    w = '{op: OP_ITER,    cond: COND_ITER_DONE, next: 4'd4};
      4'd4:    w = '{op: OP_ROUND,   cond: COND_ALWAYS,    next: 4'd5};
      4'd5:    w = '{op: OP_ERROR,   cond: COND_ALWAYS,    next: 4'd6};
      4'd6:    w = '{op: OP_PRODUCT, cond: COND_ALWAYS,    next: 4'd7};
      4'd7:    w = '{op: OP_DECIDE,  cond: COND_ALWAYS,    next: 4'd8};
      4'd8:    w = '{op: OP_EMIT,    cond: COND_OUT_FREE,  next: 4'd0};
      default: w = '{op: OP_CAPTURE, cond: COND_ALWAYS,    next: 4'd0};
    endcase
    return w;
  endfunction

  // atan(2^-i) in Q.24 radians
  function automatic logic signed [CW-1:0] atan_q24(input logic [ITER_W-1:0] idx);
    logic signed [CW-1:0] a;
    case (idx)
      5'd0:    a = 28'sd13176795;
      5'd1:    a = 28'sd7778716;
      5'd2:    a = 28'sd4110060;
      5'd3:    a = 28'sd2086331;
      5'd4:    a = 28'sd1047214;
      5'd5:    a = 28'sd524117;
      5'd6:    a = 28'sd262123;
      5'd7:    a = 28'sd131069;
      5'd8:    a = 28'sd65536;
      5'd9:    a = 28'sd32768;
      5'd10:   a = 28'sd16384;
      5'd11:   a = 28'sd8192;
      5'd12:   a = 28'sd4096;
      5'd13:   a = 28'sd2048;
      5'd14:   a = 28'sd1024;
      5'd15:   a = 28'sd512;
      5'd16:   a = 28'sd256;
      5'd17:   a = 28'sd128;
      5'd18:   a = 28'sd64;
      5'd19:   a = 28'sd32;
      5'd20:   a = 28'sd16;
      5'd21:   a = 28'sd8;
      5'd22:   a = 28'sd4;
      5'd23:   a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### src/gtg_if.sv
// Valid/ready channel interfaces for commands in and results out.
interface gtg_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [gtg_pkg::POS_W-1:0]    goal_x;
  logic signed [gtg_pkg::POS_W-1:0]    goal_y;
  logic signed [gtg_pkg::POS_W-1:0]    pose_x;
  logic signed [gtg_pkg::POS_W-1:0]    pose_y;
  logic signed [gtg_pkg::HEAD_W-1:0]   pose_heading;

  modport source (
    output valid, action, goal_x, goal_y, pose_x, pose_y, pose_heading,
    input  ready
  );
  modport sink (
    input  valid, action, goal_x, goal_y, pose_x, pose_y, pose_heading,
    output ready
  );
endinterface

interface gtg_res_if;
  logic                                valid;
  logic                                ready;
  logic [11:0]                         linear_speed;
  logic signed [gtg_pkg::ERR_W-1:0]    angular_rate;
  logic                                goal_reached;

  modport source (
    output valid, linear_speed, angular_rate, goal_reached,
    input  ready
  );
  modport sink (
    input  valid, linear_speed, angular_rate, goal_reached,
    output ready
  );
endinterface

### src/gtg_datapath.sv
// CORDIC bearing and steering datapath driven by one microcode operation per cycle.
module gtg_datapath (
  input  logic                                 clk,
  input  gtg_pkg::ctl_t                        ctl,
  input  gtg_pkg::cfg_t                        cfg,
  input  logic signed [gtg_pkg::POS_W-1:0]     target_x,
  input  logic signed [gtg_pkg::POS_W-1:0]     target_y,
  input  logic signed [gtg_pkg::POS_W-1:0]     pose_x,
  input  logic signed [gtg_pkg::POS_W-1:0]     pose_y,
  input  logic signed [gtg_pkg::HEAD_W-1:0]    pose_heading,
  output gtg_pkg::result_t                     result
);

  localparam int CW = gtg_pkg::CW;
  localparam int DW = gtg_pkg::DIFF_W;

  logic signed [gtg_pkg::POS_W-1:0]  px, py;
  logic signed [gtg_pkg::HEAD_W-1:0] ph;
  logic signed [DW-1:0]              dx, dy;
  logic [DW-1:0]                     adx, ady;
  logic                              zero_off;
  logic signed [CW-1:0]              x, y, z;
  logic signed [gtg_pkg::HEAD_W-1:0] bearing;
  logic signed [gtg_pkg::ERR_W-1:0]  err;
  logic [gtg_pkg::ERR_W-1:0]         aerr;
  logic [gtg_pkg::PROD_W-1:0]        prod;

  logic signed [CW-1:0]              dxw, dyw, xs, ys, zr;
  logic                              y_pos;
  logic [gtg_pkg::ERR_W-1:0]         rate_mag;

  // Scale offsets by 256 into the CORDIC width
  assign dxw = {{(CW-DW-8){dx[DW-1]}}, dx, 8'b0};
  assign dyw = {{(CW-DW-8){dy[DW-1]}}, dy, 8'b0};

  assign xs    = x >>> ctl.iter;
  assign ys    = y >>> ctl.iter;
  assign y_pos = !y[CW-1] && (y != '0);

  // Round Q.24 half up to Q.12
  assign zr = (z + gtg_pkg::ROUND_HALF) >>> 12;

  assign rate_mag = prod[gtg_pkg::PROD_W-1:8];

  always_ff @(posedge clk) begin
    case (ctl.op)
      gtg_pkg::OP_CAPTURE: begin
        if (ctl.take) begin
          px <= pose_x;
          py <= pose_y;
          ph <= pose_heading;
        end
      end
      gtg_pkg::OP_DIFF: begin
        dx <= {target_x[gtg_pkg::POS_W-1], target_x} - {px[gtg_pkg::POS_W-1], px};
        dy <= {target_y[gtg_pkg::POS_W-1], target_y} - {py[gtg_pkg::POS_W-1], py};
      end
      gtg_pkg::OP_PREROT: begin
        // Left half-plane: rotate by a quarter turn first
        adx      <= dx[DW-1] ? -dx : dx;
        ady      <= dy[DW-1] ? -dy : dy;
        zero_off <= (dx == '0) && (dy == '0);
        if (dx[DW-1]) begin
          if (!dy[DW-1]) begin
            x <= dyw;
            y <= -dxw;
            z <= gtg_pkg::HALF_PI_Q24;
          end else begin
            x <= -dyw;
            y <= dxw;
            z <= -gtg_pkg::HALF_PI_Q24;
          end
        end else begin
          x <= dxw;
          y <= dyw;
          z <= '0;
        end
      end
      gtg_pkg::OP_ITER: begin
        if (y_pos) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + gtg_pkg::atan_q24(ctl.iter);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - gtg_pkg::atan_q24(ctl.iter);
        end
      end
      gtg_pkg::OP_ROUND: begin
        // Clamp to plus or minus pi; a zero offset has bearing zero
        if (zero_off) begin
          bearing <= '0;
        end else if (zr > gtg_pkg::PI_Q12) begin
          bearing <= gtg_pkg::PI_Q12[gtg_pkg::HEAD_W-1:0];
        end else if (zr < -gtg_pkg::PI_Q12) begin
          bearing <= -gtg_pkg::PI_Q12[gtg_pkg::HEAD_W-1:0];
        end else begin
          bearing <= zr[gtg_pkg::HEAD_W-1:0];
        end
      end
      gtg_pkg::OP_ERROR: begin
        err  <= {bearing[gtg_pkg::HEAD_W-1], bearing} - {ph[gtg_pkg::HEAD_W-1], ph};
        aerr <= ($signed({bearing[gtg_pkg::HEAD_W-1], bearing}) <
                 $signed({ph[gtg_pkg::HEAD_W-1], ph})) ?
                ({ph[gtg_pkg::HEAD_W-1], ph} - {bearing[gtg_pkg::HEAD_W-1], bearing}) :
                ({bearing[gtg_pkg::HEAD_W-1], bearing} - {ph[gtg_pkg::HEAD_W-1], ph});
      end
      gtg_pkg::OP_PRODUCT: begin
        prod <= {8'b0, aerr} * {16'b0, cfg.gain};
      end
      gtg_pkg::OP_DECIDE: begin
        // Stop at goal, else turn in place, else drive
        if ((adx < {5'b0, cfg.pos_tol}) && (ady < {5'b0, cfg.pos_tol})) begin
          result.linear_speed <= '0;
          result.angular_rate <= '0;
          result.goal_reached <= 1'b1;
        end else if (aerr > {3'b0, cfg.ang_tol}) begin
          result.linear_speed <= '0;
          result.angular_rate <= err[gtg_pkg::ERR_W-1] ? -rate_mag : rate_mag;
          result.goal_reached <= 1'b0;
        end else begin
          result.linear_speed <= cfg.cruise;
          result.angular_rate <= '0;
          result.goal_reached <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/go_to_goal_heading_controller_top.sv
// Go-to-goal heading controller: microcode sequencer, registers and result buffer.
// A pose passes the diff, pre-rotation, CORDIC iteration, round, error, product,
// decide and emit steps; emit waits for a free output register. A new pose is taken
// only back in the capture step; set-goal and unarmed poses do not leave that step.
// The next command is taken while a result still waits in the output register.
// Reset (rst, synchronous): registers to defaults, goal cleared, controller disarmed.
module go_to_goal_heading_controller_top #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  gtg_cmd_if.sink                             cmd,
  gtg_res_if.source                           res,
  input  logic                                cfg_we,
  input  logic [gtg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gtg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int Iters = (CORDIC_STEPS < gtg_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                            : gtg_pkg::ATAN_LEN;
  localparam logic [gtg_pkg::ITER_W-1:0] IterLast = gtg_pkg::ITER_W'(Iters - 1);

  logic [gtg_pkg::PC_W-1:0]          pc, pc_next;
  logic [gtg_pkg::ITER_W-1:0]        iter;
  logic                              armed;
  logic signed [gtg_pkg::POS_W-1:0]  target_x, target_y;
  gtg_pkg::cfg_t                     cfg;
  gtg_pkg::uword_t                   word;
  gtg_pkg::ctl_t                     ctl;
  gtg_pkg::result_t                  result;
  logic                              out_valid;
  gtg_pkg::result_t                  out_data;
  logic                              cmd_take, pose_take, out_free, cond_ok;

  assign word      = gtg_pkg::rom_word(pc);
  assign cmd.ready = (word.op == gtg_pkg::OP_CAPTURE);
  assign cmd_take  = cmd.valid && cmd.ready;
  assign pose_take = cmd_take && (cmd.action == gtg_pkg::ACT_POSE) && armed;
  assign out_free  = !out_valid || res.ready;

  // Evaluate the step's advance condition
  always_comb begin
    unique case (word.cond)
      gtg_pkg::COND_ALWAYS:    cond_ok = 1'b1;
      gtg_pkg::COND_POSE:      cond_ok = pose_take;
      gtg_pkg::COND_ITER_DONE: cond_ok = (iter == IterLast);
      gtg_pkg::COND_OUT_FREE:  cond_ok = out_free;
      default:                 cond_ok = 1'b0;
    endcase
  end

  assign pc_next = cond_ok ? word.next : pc;

  assign ctl.op   = word.op;
  assign ctl.take = pose_take;
  assign ctl.iter = iter;

  // Advance the step counter and the iteration index
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      iter <= '0;
    end else begin
      pc <= pc_next;
      if (word.op == gtg_pkg::OP_PREROT) begin
        iter <= '0;
      end else if ((word.op == gtg_pkg::OP_ITER) && !cond_ok) begin
        iter <= iter + 1'b1;
      end
    end
  end

  // Store the goal and arm on a set-goal transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b0;
      target_x <= '0;
      target_y <= '0;
    end else if (cmd_take && (cmd.action == gtg_pkg::ACT_SET_GOAL)) begin
      armed    <= 1'b1;
      target_x <= cmd.goal_x;
      target_y <= cmd.goal_y;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_tol <= gtg_pkg::POS_TOL_RST;
      cfg.ang_tol <= gtg_pkg::ANG_TOL_RST;
      cfg.gain    <= gtg_pkg::GAIN_RST;
      cfg.cruise  <= gtg_pkg::CRUISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtg_pkg::CFG_POS_TOL: cfg.pos_tol <= cfg_data[11:0];
        gtg_pkg::CFG_ANG_TOL: cfg.ang_tol <= cfg_data[12:0];
        gtg_pkg::CFG_GAIN:    cfg.gain    <= cfg_data[7:0];
        gtg_pkg::CFG_CRUISE:  cfg.cruise  <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  gtg_datapath u_datapath (
    .clk          (clk),
    .ctl          (ctl),
    .cfg          (cfg),
    .target_x     (target_x),
    .target_y     (target_y),
    .pose_x       (cmd.pose_x),
    .pose_y       (cmd.pose_y),
    .pose_heading (cmd.pose_heading),
    .result       (result)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((word.op == gtg_pkg::OP_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((word.op == gtg_pkg::OP_EMIT) && out_free) begin
      out_data <= result;
    end
  end

  assign res.valid        = out_valid;
  assign res.linear_speed = out_data.linear_speed;
  assign res.angular_rate = out_data.angular_rate;
  assign res.goal_reached = out_data.goal_reached;

`ifndef SYNTHESIS
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || res.ready) ##1 out_valid |-> $past(word.op == gtg_pkg::OP_EMIT))
    else $error("result loaded outside the emit step");

  a_unarmed_drop: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && (cmd.action == gtg_pkg::ACT_POSE) && !armed) |=> (pc == '0))
    else $error("pose before a goal left the idle step");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    (word.op == gtg_pkg::OP_ITER) |-> (iter <= IterLast))
    else $error("CORDIC iteration index past the last step");
`endif

endmodule
